[rtl/core/icov_pkg.sv]
package icov_pkg;

   localparam int POSITIONS = 1024;
   localparam int POS_W     = 11;
   localparam int IDX_W     = $clog2(POSITIONS);
   localparam int WORD_W    = 32;
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int WORDS     = POSITIONS / WORD_W;
   localparam int WADDR_W   = $clog2(WORDS);
   localparam int COUNT_W   = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic hit;
      logic full;
   } word_status_type;

   // One bit per position of the word: set where the position lies in lo..hi.
   function automatic logic [WORD_W-1:0] range_mask(input logic [WADDR_W-1:0] word,
                                                    input logic [IDX_W-1:0]   lo,
                                                    input logic [IDX_W-1:0]   hi);
      logic [WORD_W-1:0] mask;
      logic [IDX_W-1:0]  pos;
      mask = '0;
      for (int b = 0; b < WORD_W; b++) begin
         pos     = {word, BIT_W'(b)};
         mask[b] = (pos >= lo) && (pos <= hi);
      end
      return mask;
   endfunction

endpackage

[rtl/core/icov_ram.sv]
module icov_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/icov_word_unit.sv]
module icov_word_unit (
   input  logic [icov_pkg::WADDR_W-1:0] word_index,
   input  logic [icov_pkg::IDX_W-1:0]   lo_index,
   input  logic [icov_pkg::IDX_W-1:0]   hi_index,
   input  logic [icov_pkg::WORD_W-1:0]  word_data,
   output logic [icov_pkg::WORD_W-1:0]  merged_data,
   output icov_pkg::word_status_type    status
);
   import icov_pkg::*;

   logic [WORD_W-1:0] mask;

   always_comb begin
      mask        = range_mask(word_index, lo_index, hi_index);
      merged_data = word_data | mask;
      status.hit  = |(mask & ~word_data);
      status.full = &merged_data;
   end

endmodule

[rtl/core/interval_coverage_tracker_unit.sv]
// Marks inclusive ranges of positions 1..1024 as covered, one range per
// transaction, and returns one result per transaction: whether the range
// reached a position that was still uncovered, whether positions 1 through
// the span are now all covered, a saturating count of ranges that covered
// something new, and an error flag for a rejected range. Coverage is kept as
// 32 words of 32 bits in a RAM with a full flag per word; a shared word unit
// merges one word per cycle. After it accepts a transaction the block is busy
// in its check state, then scans each 32-position word the range touches (1
// to 32), then reads and checks the span word and ends in its done state, so
// it accepts no new transaction before the previous one is done; a rejected
// range skips the scan. If the previous result has not been taken yet, the
// block holds in its done state until it is.
// After reset the block clears all 32 RAM words before it accepts the
// first transaction.
module interval_coverage_tracker_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [icov_pkg::POS_W-1:0]   req_range_start,
   input  logic [icov_pkg::POS_W-1:0]   req_range_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_newly_covered,
   output logic                         rsp_span_full,
   output logic [icov_pkg::COUNT_W-1:0] rsp_visible_count,
   output logic                         rsp_range_error,
   input  logic                         csr_write_enable,
   input  logic [icov_pkg::POS_W-1:0]   csr_write_data
);
   import icov_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_SPAN_RD,
      ST_SPAN_CHK,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [WADDR_W-1:0]   clr_ff, clr_in;
   logic [WADDR_W-1:0]   word_ff, word_in;
   logic [POS_W-1:0]     start_ff, start_in;
   logic [POS_W-1:0]     end_ff, end_in;
   logic [POS_W-1:0]     span_ff, span_in;
   logic [WORDS-1:0]     full_ff, full_in;
   logic                 hit_ff, hit_in;
   logic                 err_ff, err_in;
   logic                 span_full_ff, span_full_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_new_ff, rsp_new_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_err_ff, rsp_err_in;

   logic [POS_W-1:0]     span_eff;
   logic [POS_W-1:0]     span_m1;
   logic [POS_W-1:0]     lo_m1;
   logic [POS_W-1:0]     hi_m1;
   logic [IDX_W-1:0]     lo_idx;
   logic [IDX_W-1:0]     hi_idx;
   logic [IDX_W-1:0]     span_idx;
   logic [WADDR_W-1:0]   lo_word;
   logic [WADDR_W-1:0]   hi_word;
   logic [WADDR_W-1:0]   span_word;
   logic [WORDS-1:0]     below_mask;
   logic [WORD_W-1:0]    tail_mask;
   logic                 range_bad;

   logic                 ram_wr_en;
   logic [WADDR_W-1:0]   ram_wr_addr;
   logic [WORD_W-1:0]    ram_wr_data;
   logic [WADDR_W-1:0]   ram_rd_addr;
   logic [WORD_W-1:0]    ram_rd_data;
   logic [WORD_W-1:0]    merged_data;
   word_status_type      word_status;

   icov_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_cover_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   icov_word_unit u_word_unit (
      .word_index  (word_ff),
      .lo_index    (lo_idx),
      .hi_index    (hi_idx),
      .word_data   (ram_rd_data),
      .merged_data (merged_data),
      .status      (word_status)
   );

   always_comb begin
      if (span_ff == '0) begin
         span_eff = POS_W'(1);
      end else if (span_ff > POS_W'(POSITIONS)) begin
         span_eff = POS_W'(POSITIONS);
      end else begin
         span_eff = span_ff;
      end
      span_m1   = span_eff - POS_W'(1);
      lo_m1     = start_ff - POS_W'(1);
      hi_m1     = end_ff - POS_W'(1);
      span_idx  = span_m1[IDX_W-1:0];
      lo_idx    = lo_m1[IDX_W-1:0];
      hi_idx    = hi_m1[IDX_W-1:0];
      span_word = span_idx[IDX_W-1:BIT_W];
      lo_word   = lo_idx[IDX_W-1:BIT_W];
      hi_word   = hi_idx[IDX_W-1:BIT_W];
      range_bad = (start_ff == '0) || (start_ff > end_ff) || (end_ff > span_eff);
      for (int w = 0; w < WORDS; w++) begin
         below_mask[w] = WADDR_W'(w) < span_word;
      end
      tail_mask = range_mask(span_word, '0, span_idx);
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      word_in       = word_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      span_in       = csr_write_enable ? csr_write_data : span_ff;
      full_in       = full_ff;
      hit_in        = hit_ff;
      err_in        = err_ff;
      span_full_in  = span_full_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_new_in    = rsp_new_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_err_in    = rsp_err_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = word_ff;
      ram_wr_data   = merged_data;
      ram_rd_addr   = word_ff;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = WADDR_W'(clr_ff + 1'b1);
            if (clr_ff == WADDR_W'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               start_in = req_range_start;
               end_in   = req_range_end;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            err_in      = range_bad;
            hit_in      = 1'b0;
            word_in     = lo_word;
            ram_rd_addr = lo_word;
            state_in    = range_bad ? ST_SPAN_RD : ST_SCAN;
         end
         ST_SCAN: begin
            ram_wr_en        = 1'b1;
            hit_in           = hit_ff | word_status.hit;
            full_in[word_ff] = word_status.full;
            ram_rd_addr      = WADDR_W'(word_ff + 1'b1);
            word_in          = WADDR_W'(word_ff + 1'b1);
            if (word_ff == hi_word) begin
               state_in = ST_SPAN_RD;
            end
         end
         ST_SPAN_RD: begin
            ram_rd_addr = span_word;
            state_in    = ST_SPAN_CHK;
         end
         ST_SPAN_CHK: begin
            span_full_in = (&(full_ff | ~below_mask)) && (&(ram_rd_data | ~tail_mask));
            if (hit_ff && (count_ff != COUNT_MAX)) begin
               count_in = count_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_new_in   = hit_ff;
               rsp_full_in  = span_full_ff;
               rsp_count_in = count_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         span_ff      <= POS_W'(POSITIONS);
         full_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         span_ff      <= span_in;
         full_ff      <= full_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff      <= word_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      hit_ff       <= hit_in;
      err_ff       <= err_in;
      span_full_ff <= span_full_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_newly_covered = rsp_new_ff;
   assign rsp_span_full     = rsp_full_ff;
   assign rsp_visible_count = rsp_count_ff;
   assign rsp_range_error   = rsp_err_ff;

endmodule

[rtl/core/icov_checker.sv]
module icov_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_newly_covered,
   input logic                         rsp_span_full,
   input logic [icov_pkg::COUNT_W-1:0] rsp_visible_count,
   input logic                         rsp_range_error
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_newly_covered)
         && $stable(rsp_span_full) && $stable(rsp_visible_count)
         && $stable(rsp_range_error))
      else $error("result changed while stalled");

   // The block works on one transaction at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted transaction");

   // A rejected range never covers anything.
   a_error_no_cover: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> !rsp_newly_covered)
      else $error("rejected range reported new coverage");

   // A range that covered something new has been counted.
   a_cover_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_newly_covered |-> rsp_visible_count != '0)
      else $error("new coverage with a zero count");

endmodule

bind interval_coverage_tracker_unit icov_checker u_icov_checker (.*);
